### src/gdb_pkg.sv
`default_nettype none

package gdb_pkg;

   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 15;
   localparam int YY_W       = 16;
   localparam int Q100_W     = 9;
   localparam int OFF_W      = 9;
   localparam int LEN_W      = 5;
   localparam int DAY_NUM_W  = 24;
   localparam int COUNT_W    = 24;

   // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for every 15-bit year
   localparam int DIV100_MUL_W = 18;
   localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 18'd167773;
   localparam int DIV100_SHIFT = 24;

   localparam logic [YY_W-1:0]   YEAR_BIAS  = 16'd400;
   localparam logic [Q100_W-1:0] BIAS_Q100  = 9'd4;
   localparam logic [MONTH_W-1:0] MARCH     = 4'd3;

   typedef logic [DAY_NUM_W-1:0] day_num_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   // days before the first of month m in a year that starts in march
   function automatic logic [OFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [OFF_W-1:0] off;
      case (m)
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

   // zero for a month that does not exist
   function automatic logic [LEN_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [LEN_W-1:0] len;
      case (m)
         4'd2:                        len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:          len = 5'd31;
         default:                     len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

### src/gdb_date_path.sv
`default_nettype none

module gdb_date_path (
   input  wire logic                          clock,
   input  wire gdb_pkg::stage_en_type         stage_en,
   input  wire logic [gdb_pkg::DAY_W-1:0]     day,
   input  wire logic [gdb_pkg::MONTH_W-1:0]   month,
   input  wire logic [gdb_pkg::YEAR_W-1:0]    year,
   output gdb_pkg::day_num_type               day_num,
   output logic                               date_ok
);

   localparam int PROD_W = gdb_pkg::YEAR_W + gdb_pkg::DIV100_MUL_W;

   // stage 1: year / 100
   logic [PROD_W-1:0]               prod;
   logic [gdb_pkg::YEAR_W-1:0]      year1_ff,  year1_in;
   logic [gdb_pkg::Q100_W-1:0]      q100_1_ff, q100_1_in;
   logic                            jan_feb1_ff, jan_feb1_in;
   logic [gdb_pkg::MONTH_W-1:0]     month1_ff, month1_in;
   logic [gdb_pkg::DAY_W-1:0]       day1_ff,   day1_in;

   // stage 2: leap and range checks, shifted year
   logic [gdb_pkg::YY_W-1:0]        q_times100;
   logic                            cent_year;
   logic                            leap;
   logic [gdb_pkg::LEN_W-1:0]       len;
   logic [gdb_pkg::YY_W-1:0]        yy2_ff,    yy2_in;
   logic [gdb_pkg::Q100_W-1:0]      c2_ff,     c2_in;
   logic [gdb_pkg::OFF_W-1:0]       off2_ff,   off2_in;
   logic [gdb_pkg::DAY_W-1:0]       day2_ff,   day2_in;
   logic                            ok2_ff,    ok2_in;

   // stage 3: day number
   gdb_pkg::day_num_type            dn3_ff,    dn3_in;
   logic                            ok3_ff,    ok3_in;

   always_comb begin
      prod        = PROD_W'(year) * PROD_W'(gdb_pkg::DIV100_MUL);
      year1_in    = year;
      q100_1_in   = prod[gdb_pkg::DIV100_SHIFT +: gdb_pkg::Q100_W];
      jan_feb1_in = (month < gdb_pkg::MARCH);
      month1_in   = month;
      day1_in     = day;
   end

   always_comb begin
      q_times100 = (gdb_pkg::YY_W'(q100_1_ff) << 6) + (gdb_pkg::YY_W'(q100_1_ff) << 5)
                 + (gdb_pkg::YY_W'(q100_1_ff) << 2);
      cent_year  = (q_times100 == gdb_pkg::YY_W'(year1_ff));
      leap       = (year1_ff[1:0] == 2'd0) && (!cent_year || (q100_1_ff[1:0] == 2'd0));
      len        = gdb_pkg::month_days(month1_ff, leap);
      // jan and feb count as months of the year before
      yy2_in     = gdb_pkg::YY_W'(year1_ff) + gdb_pkg::YEAR_BIAS
                 - gdb_pkg::YY_W'(jan_feb1_ff);
      c2_in      = q100_1_ff + gdb_pkg::BIAS_Q100
                 - gdb_pkg::Q100_W'(jan_feb1_ff & cent_year);
      off2_in    = gdb_pkg::month_offset(month1_ff);
      day2_in    = day1_ff;
      ok2_in     = (len != '0) && (day1_ff != '0) && (day1_ff <= len);
   end

   always_comb begin
      dn3_in = gdb_pkg::DAY_NUM_W'(yy2_ff) * gdb_pkg::DAY_NUM_W'(365)
             + gdb_pkg::DAY_NUM_W'(yy2_ff >> 2)
             - gdb_pkg::DAY_NUM_W'(c2_ff)
             + gdb_pkg::DAY_NUM_W'(c2_ff >> 2)
             + gdb_pkg::DAY_NUM_W'(off2_ff)
             + gdb_pkg::DAY_NUM_W'(day2_ff)
             - gdb_pkg::DAY_NUM_W'(1);
      ok3_in = ok2_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         year1_ff    <= year1_in;
         q100_1_ff   <= q100_1_in;
         jan_feb1_ff <= jan_feb1_in;
         month1_ff   <= month1_in;
         day1_ff     <= day1_in;
      end
      if (stage_en.s2) begin
         yy2_ff  <= yy2_in;
         c2_ff   <= c2_in;
         off2_ff <= off2_in;
         day2_ff <= day2_in;
         ok2_ff  <= ok2_in;
      end
      if (stage_en.s3) begin
         dn3_ff <= dn3_in;
         ok3_ff <= ok3_in;
      end
   end

   assign day_num = dn3_ff;
   assign date_ok = ok3_ff;

endmodule

`default_nettype wire

### src/gregorian_days_between_dates.sv
// throughput: one item per cycle while rsp_stall is low, through four register stages
// (divide-by-100 multiply, leap and range check, day-number sum, compare and subtract)
// reset: synchronous, active high; clears all stage valid bits, payload is not reset
`default_nettype none

module gregorian_days_between_dates (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [gdb_pkg::DAY_W-1:0]       req_start_day,
   input  wire logic [gdb_pkg::MONTH_W-1:0]     req_start_month,
   input  wire logic [gdb_pkg::YEAR_W-1:0]      req_start_year,
   input  wire logic [gdb_pkg::DAY_W-1:0]       req_end_day,
   input  wire logic [gdb_pkg::MONTH_W-1:0]     req_end_month,
   input  wire logic [gdb_pkg::YEAR_W-1:0]      req_end_year,
   input  wire logic                            req_include_end,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [gdb_pkg::COUNT_W-1:0]          rsp_day_count,
   output logic                                 rsp_bad_date
);

   // per-stage valid bits, one for each register stage
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic v4_ff, v4_in;

   // a stage may load when it is empty or the stage after it loads
   logic rdy1, rdy2, rdy3, rdy4;
   gdb_pkg::stage_en_type stage_en;

   // include_end rides alongside the two date paths
   logic inc1_ff, inc1_in;
   logic inc2_ff, inc2_in;
   logic inc3_ff, inc3_in;

   gdb_pkg::day_num_type start_num, end_num;
   logic start_ok, end_ok;

   // output register
   logic [gdb_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        bad_ff,   bad_in;
   logic [gdb_pkg::COUNT_W-1:0] span;

   // ready chain runs back from the output; bubbles are squeezed out
   always_comb begin
      rdy4        = !v4_ff || !rsp_stall;
      rdy3        = !v3_ff || rdy4;
      rdy2        = !v2_ff || rdy3;
      rdy1        = !v1_ff || rdy2;
      stage_en.s1 = rdy1;
      stage_en.s2 = rdy2;
      stage_en.s3 = rdy3;
      req_stall   = !rdy1;
   end

   // valid bits move with the data
   always_comb begin
      v1_in = rdy1 ? req_valid : v1_ff;
      v2_in = rdy2 ? v1_ff     : v2_ff;
      v3_in = rdy3 ? v2_ff     : v3_ff;
      v4_in = rdy4 ? v3_ff     : v4_ff;
      inc1_in = req_include_end;
      inc2_in = inc1_ff;
      inc3_in = inc2_ff;
   end

   gdb_date_path u_start (
      .clock    (clock),
      .stage_en (stage_en),
      .day      (req_start_day),
      .month    (req_start_month),
      .year     (req_start_year),
      .day_num  (start_num),
      .date_ok  (start_ok)
   );

   gdb_date_path u_end (
      .clock    (clock),
      .stage_en (stage_en),
      .day      (req_end_day),
      .month    (req_end_month),
      .year     (req_end_year),
      .day_num  (end_num),
      .date_ok  (end_ok)
   );

   // final stage: compare day numbers, clamp to zero, add the end day if asked
   always_comb begin
      span = (start_num < end_num) ? gdb_pkg::COUNT_W'(end_num - start_num) : '0;
      if (!start_ok || !end_ok) begin
         // impossible date: no count at all, include_end ignored
         count_in = '0;
         bad_in   = 1'b1;
      end else begin
         count_in = span + gdb_pkg::COUNT_W'(inc3_ff);
         bad_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         inc1_ff <= inc1_in;
      end
      if (rdy2) begin
         inc2_ff <= inc2_in;
      end
      if (rdy3) begin
         inc3_ff <= inc3_in;
      end
      if (rdy4) begin
         count_ff <= count_in;
         bad_ff   <= bad_in;
      end
   end

   assign rsp_valid     = v4_ff;
   assign rsp_day_count = count_ff;
   assign rsp_bad_date  = bad_ff;

   // a flagged date never carries a count
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_date |-> rsp_day_count == '0)
      else $error("bad date with nonzero count");

   // input stalls only when every stage holds an item and the output is stalled
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // an item in stage 3 reaches the output register when the output is not stalled
   a_drain: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rsp_stall |=> rsp_valid)
      else $error("item lost between stage 3 and output");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !v1_ff && !v2_ff && !v3_ff && !v4_ff)
      else $error("valid bit survived reset");

endmodule

`default_nettype wire
